// ===== rtl/vfbe_pkg.sv =====
// vfbe_pkg: shared types, constants and the varicode lookup for the
// varicode FSK bit encoder. No dependencies.
`default_nettype none

package vfbe_pkg;

    // field and port widths
    localparam int CHAR_W      = 7;
    localparam int CODE_W      = 10;                 // longest varicode word
    localparam int LEN_W       = $clog2(CODE_W + 1);
    localparam int CENTER_W    = 26;
    localparam int SHIFT_W     = 17;
    localparam int TONE_W      = 26;
    localparam int CFG_DATA_W  = 26;
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam int MAX_CODE_BITS_DEF = 10;
    localparam int SYNC_PAIRS_DEF    = 10;

    localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(3575000);
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(170);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER = 1'b0,
        REG_SHIFT  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        FUNC_CHAR = 1'b0,
        FUNC_SYNC = 1'b1
    } t_func;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take the input beat
        logic step;   // produce one output bit
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // input beat yields no bits
        logic last;      // next bit is the final one of the item
        logic out_free;  // output register can take a bit this cycle
    } t_dp_sts;

    typedef struct packed {
        logic [CODE_W-1:0] code;  // left-justified: first bit in the MSB
        logic [LEN_W-1:0]  len;
    } t_code_ent;

    // code word, first sent bit = highest set bit; zero means no entry
    localparam logic [CODE_W-1:0] CODE_TABLE [128] = '{
        10'h2AB, 10'h2DB, 10'h2ED, 10'h377, 10'h2EB, 10'h35F, 10'h2EF, 10'h2FD,
        10'h2FF, 10'h0EF, 10'h01D, 10'h36F, 10'h2DD, 10'h01F, 10'h375, 10'h3AB,
        10'h2F7, 10'h2F5, 10'h3AD, 10'h3AF, 10'h35B, 10'h36B, 10'h36D, 10'h357,
        10'h37B, 10'h37D, 10'h3B7, 10'h355, 10'h35D, 10'h3BB, 10'h2FB, 10'h37F,
        10'h001, 10'h1FF, 10'h15F, 10'h1F5, 10'h1DB, 10'h2D5, 10'h2BB, 10'h17F,
        10'h0FB, 10'h0F7, 10'h16F, 10'h1DF, 10'h075, 10'h035, 10'h057, 10'h1AF,
        10'h0B7, 10'h0BD, 10'h0ED, 10'h0FF, 10'h177, 10'h15B, 10'h16B, 10'h1AD,
        10'h1AB, 10'h1B7, 10'h0F5, 10'h1BD, 10'h1ED, 10'h055, 10'h1D7, 10'h2AF,
        10'h2BD, 10'h07D, 10'h0EB, 10'h0AD, 10'h0B5, 10'h077, 10'h0DB, 10'h0FD,
        10'h155, 10'h07F, 10'h1FD, 10'h17D, 10'h0D7, 10'h0BB, 10'h0DD, 10'h0AB,
        10'h0D5, 10'h1DD, 10'h0AF, 10'h06F, 10'h06D, 10'h157, 10'h1B5, 10'h15D,
        10'h175, 10'h17B, 10'h2AD, 10'h1F7, 10'h1EF, 10'h1FB, 10'h2BF, 10'h16D,
        10'h2DF, 10'h00B, 10'h05F, 10'h02F, 10'h02D, 10'h003, 10'h03D, 10'h05B,
        10'h02B, 10'h00D, 10'h1EB, 10'h0BF, 10'h01B, 10'h03B, 10'h00F, 10'h007,
        10'h03F, 10'h1BF, 10'h015, 10'h017, 10'h005, 10'h037, 10'h07B, 10'h06B,
        10'h0DF, 10'h05D, 10'h1D5, 10'h2B7, 10'h1BB, 10'h2B5, 10'h2D7, 10'h000
    };

    // ROM lookup: length and left-justified code word for one character
    function automatic t_code_ent code_lookup(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] c;
        logic [LEN_W-1:0]  n;
        t_code_ent         ent;
        c = CODE_TABLE[ch];
        n = '0;
        for (int i = 0; i < CODE_W; i++) begin
            if (c[i]) n = LEN_W'(i + 1);
        end
        ent.len  = n;
        ent.code = c << (CODE_W - int'(n));
        return ent;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vfbe_ctrl.sv =====
// vfbe_ctrl: two-state sequencer for the varicode FSK bit encoder.
// Depends on vfbe_pkg for the state type and the command/status structs.
`default_nettype none

module vfbe_ctrl
    import vfbe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                // an item with no code word never leaves idle
                if (i_s_tvalid && !i_sts.empty) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_EMIT: begin
                o_cmd.step = i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vfbe_dpath.sv =====
// vfbe_dpath: config registers, tone arithmetic, bit shifter, beat counter
// and output register. Depends on vfbe_pkg; driven by vfbe_ctrl commands.
`default_nettype none

module vfbe_dpath
    import vfbe_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int SYNC_PAIRS    = SYNC_PAIRS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts
);

    localparam int CHAR_BEATS = MAX_CODE_BITS + 2;
    localparam int SYNC_BEATS = 2 * SYNC_PAIRS;
    localparam int MAX_BEATS  = (CHAR_BEATS > SYNC_BEATS) ? CHAR_BEATS : SYNC_BEATS;
    localparam int CNT_W      = $clog2(MAX_BEATS + 1);

    logic [CENTER_W-1:0]      r_center;
    logic [SHIFT_W-1:0]       r_shift;
    logic                     r_func;
    logic [MAX_CODE_BITS-1:0] r_sh;
    logic [CNT_W-1:0]         r_rem;
    logic                     r_ov;
    logic                     r_obit;
    logic [TONE_W-1:0]        r_otone;
    logic                     r_olast;

    t_code_ent           ent;
    logic [CENTER_W:0]   mark_sum;
    logic [TONE_W-1:0]   mark_tone;
    logic [TONE_W-1:0]   space_tone;
    logic                cur_bit;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= CENTER_RST;
            r_shift  <= SHIFT_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_CENTER: r_center <= i_cfg_wdata[CENTER_W-1:0];
                REG_SHIFT:  r_shift  <= i_cfg_wdata[SHIFT_W-1:0];
                default:    r_center <= r_center;
            endcase
        end
    end

    // saturated mark and space tones
    always_comb begin
        mark_sum  = {1'b0, r_center} + (CENTER_W + 1)'(r_shift);
        mark_tone = mark_sum[CENTER_W] ? '1 : mark_sum[TONE_W-1:0];
        space_tone = (r_center >= CENTER_W'(r_shift)) ?
                     (r_center - CENTER_W'(r_shift)) : '0;
    end

    assign ent = code_lookup(i_s_tdata[CHAR_W-1:0]);

    // sync alternates mark/space starting on an even count; a character
    // shifts out its left-justified code, zeros fill in the separator
    assign cur_bit = r_func ? ~r_rem[0] : r_sh[MAX_CODE_BITS-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_tuser;
            r_sh   <= MAX_CODE_BITS'(ent.code) << (MAX_CODE_BITS - CODE_W);
            if (t_func'(i_s_tuser) == FUNC_SYNC) begin
                r_rem <= CNT_W'(SYNC_BEATS);
            end else begin
                r_rem <= CNT_W'(ent.len) + CNT_W'(2);
            end
        end else if (i_cmd.step) begin
            r_sh  <= r_sh << 1;
            r_rem <= r_rem - CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.step) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_obit  <= cur_bit;
            r_otone <= cur_bit ? mark_tone : space_tone;
            r_olast <= (r_rem == CNT_W'(1));
        end
    end

    always_comb begin
        o_sts.empty    = (t_func'(i_s_tuser) == FUNC_CHAR) && (ent.len == '0);
        o_sts.last     = (r_rem == CNT_W'(1));
        o_sts.out_free = !r_ov || i_m_tready;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(OUT_TDATA_W - TONE_W - 1){1'b0}}, r_otone, r_obit};
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

// ===== rtl/varicode_fsk_bit_encoder.sv =====
// Varicode FSK bit encoder: one input beat in, one bit per output beat out.
// An item loads the code shifter and beat counter; no new item is taken until
// its last bit has gone to the output register. A character gives code length
// + 2 beats (3 to 12), a sync item 2*SYNC_PAIRS, one bit per cycle unless stalled.
// Character 127 is taken without a stall and yields no beats.
// Reset (i_rst_n, sync, active low): center 3575000 Hz, shift 170 Hz, idle.
`default_nettype none

module varicode_fsk_bit_encoder
    import vfbe_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int SYNC_PAIRS    = SYNC_PAIRS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,   // 0 center_hz, 1 shift_hz
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,    // [6:0] char_code, [7] zero
    input  wire logic                   i_s_tuser,    // [0] func
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,    // [0] bit_value, [26:1] tone_hz
    output logic                        o_m_tlast     // last_bit
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    vfbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vfbe_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYNC_PAIRS    (SYNC_PAIRS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/vfbe_chk.sv =====
// vfbe_chk: port-level checks for varicode_fsk_bit_encoder, bound to the top.
// Depends on vfbe_pkg for widths.
`default_nettype none

module vfbe_chk
    import vfbe_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_tvalid,
    input wire logic                   o_s_tready,
    input wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic                   i_s_tuser,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tlast
);

    logic in_beat;
    logic in_empty;

    assign in_beat  = i_s_tvalid && o_s_tready;
    assign in_empty = !i_s_tuser && (i_s_tdata[CHAR_W-1:0] == '1);

    // an item that yields bits holds off the next one
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !in_empty) |=> !o_s_tready)
        else $error("input still ready after an item with bits");

    // character 127 is swallowed without stalling
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && in_empty) |=> o_s_tready)
        else $error("empty item stalled the input");

    // every item ends on a space bit
    a_last_is_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[0])
        else $error("final beat is not a space");

    // ready comes back only once the final beat has been produced
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_s_tready)) |-> (o_m_tvalid && o_m_tlast))
        else $error("input ready before the final beat");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind varicode_fsk_bit_encoder vfbe_chk u_vfbe_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
